[src/cic_pkg.sv]
// ----------------------------------------------------------------------------
// cic_pkg - shared types and constants
// Item kinds, port bases, command codes and the per-unit bundles used by the
// cascaded interrupt controller.
// ----------------------------------------------------------------------------
package cic_pkg;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_RAISE = 2'd2,
    KIND_DROP  = 2'd3
  } cic_kind_e;

  // Port bases (bit 0 selects command or mask port)
  localparam logic [15:0] PRI_BASE = 16'h0020;
  localparam logic [15:0] SEC_BASE = 16'h00a0;

  // Read-select codes (code 3 is never written and reads as buffered)
  localparam logic [1:0] RSEL_RAW = 2'd0;
  localparam logic [1:0] RSEL_ISR = 2'd1;
  localparam logic [1:0] RSEL_BUF = 2'd2;

  // Command port codes
  localparam logic [7:0] CMD_RSEL_RAW = 8'h0a;
  localparam logic [7:0] CMD_RSEL_ISR = 8'h0b;
  localparam logic [7:0] CMD_RSEL_BUF = 8'h0c;
  localparam logic [7:0] CMD_ICW1_LO  = 8'h10;
  localparam logic [7:0] CMD_ICW1_HI  = 8'h1f;
  localparam logic [7:0] CMD_NSEOI_LO = 8'h20;
  localparam logic [7:0] CMD_NSEOI_HI = 8'h27;
  localparam logic [7:0] CMD_SEOI_LO  = 8'h60;
  localparam logic [7:0] CMD_SEOI_HI  = 8'h67;

  localparam logic [7:0] RD_BUF_BASE = 8'h80;
  localparam logic [7:0] MASK_RESET  = 8'hff;
  localparam logic [1:0] ICW_WORDS   = 2'd2;

  // Decoded item as seen by one unit
  typedef struct packed {
    cic_kind_e  kind;
    logic       hit;       // bus address maps to this unit
    logic       odd;       // mask port
    logic [7:0] wdata;
    logic       line_hit;  // request line belongs to this unit
    logic [7:0] line_bit;  // one-hot request line within the unit
  } cic_op_t;

  // Request and mask words of one unit
  typedef struct packed {
    logic [7:0] req;
    logic [7:0] mask;
  } cic_state_t;

endpackage

[src/cic_req_if.sv]
// ----------------------------------------------------------------------------
// cic_req_if - input item channel
// Valid/ready channel carrying bus accesses and request line events.
// ----------------------------------------------------------------------------
interface cic_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] addr;
  logic [7:0]  wdata;
  logic [3:0]  irq_line;

  modport source (output valid, output req_type, output addr, output wdata,
                  output irq_line, input ready);
  modport sink   (input valid, input req_type, input addr, input wdata,
                  input irq_line, output ready);
endinterface

[src/cic_rsp_if.sv]
// ----------------------------------------------------------------------------
// cic_rsp_if - result item channel
// Valid/ready channel carrying read data and interrupt status.
// ----------------------------------------------------------------------------
interface cic_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic       cpu_irq;
  logic       bad_command;

  modport source (output valid, output rdata, output cpu_irq,
                  output bad_command, input ready);
  modport sink   (input valid, input rdata, input cpu_irq,
                  input bad_command, output ready);
endinterface

[src/cic_unit.sv]
// ----------------------------------------------------------------------------
// cic_unit - one 8259-style controller
// Holds mask, requests, read select and init countdown; decodes one item
// and produces its next state, read data and undefined-command flag.
// ----------------------------------------------------------------------------
module cic_unit import cic_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       commit_i,
  input  cic_op_t    op_i,
  input  logic [7:0] req_eff_i,   // requests with the cascade bit applied
  output cic_state_t cur_o,
  output cic_state_t nxt_o,
  output logic [7:0] rdata_o,
  output logic       bad_o
);

  logic [7:0] mask_q, mask_d;
  logic [7:0] req_q, req_d;
  logic [1:0] rsel_q, rsel_d;
  logic [1:0] init_q, init_d;

  logic [7:0] pend;
  logic [7:0] service;
  logic [7:0] buf_rd;
  logic [2:0] low_idx;
  logic       low_found;
  logic [7:0] cmd;

  assign pend    = req_eff_i & ~mask_q;
  assign service = pend & (~pend + 8'd1);
  assign cmd     = op_i.wdata;

  // Lowest set request, masked or not
  always_comb begin
    low_idx   = '0;
    low_found = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (req_eff_i[i]) begin
        low_idx   = 3'(i);
        low_found = 1'b1;
      end
    end
    buf_rd = low_found ? (RD_BUF_BASE | {5'd0, low_idx}) : 8'd0;
  end

  always_comb begin
    req_d   = req_eff_i;
    mask_d  = mask_q;
    rsel_d  = rsel_q;
    init_d  = init_q;
    rdata_o = '0;
    bad_o   = 1'b0;
    unique case (op_i.kind)
      KIND_READ: begin
        if (op_i.hit) begin
          if (op_i.odd) begin
            rdata_o = mask_q;
          end else begin
            unique case (rsel_q)
              RSEL_RAW: rdata_o = req_eff_i;
              RSEL_ISR: rdata_o = service;
              default:  rdata_o = buf_rd;
            endcase
          end
        end
      end
      KIND_WRITE: begin
        if (op_i.hit) begin
          if (!op_i.odd) begin
            priority if (cmd == CMD_RSEL_RAW) begin
              rsel_d = RSEL_RAW;
            end else if (cmd == CMD_RSEL_ISR) begin
              rsel_d = RSEL_ISR;
            end else if (cmd == CMD_RSEL_BUF) begin
              rsel_d = RSEL_BUF;
            end else if (cmd >= CMD_ICW1_LO && cmd <= CMD_ICW1_HI) begin
              init_d = ICW_WORDS + {1'b0, cmd[0]};
            end else if (cmd >= CMD_NSEOI_LO && cmd <= CMD_NSEOI_HI) begin
              req_d = req_eff_i & ~service;
            end else if (cmd >= CMD_SEOI_LO && cmd <= CMD_SEOI_HI) begin
              req_d = req_eff_i & ~(8'd1 << cmd[2:0]);
            end else begin
              bad_o = 1'b1;
            end
          end else if (init_q != 2'd0) begin
            init_d = init_q - 2'd1;
          end else begin
            mask_d = op_i.wdata;
          end
        end
      end
      KIND_RAISE: begin
        if (op_i.line_hit) req_d = req_eff_i | op_i.line_bit;
      end
      KIND_DROP: begin
        if (op_i.line_hit) req_d = req_eff_i & ~op_i.line_bit;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= MASK_RESET;
      req_q  <= '0;
      rsel_q <= RSEL_BUF;
      init_q <= '0;
    end else if (commit_i) begin
      mask_q <= mask_d;
      req_q  <= req_d;
      rsel_q <= rsel_d;
      init_q <= init_d;
    end
  end

  assign cur_o = '{req: req_q, mask: mask_q};
  assign nxt_o = '{req: req_d, mask: mask_d};

  // Hold everything while no item commits
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !commit_i |=> $stable(mask_q) && $stable(req_q) && $stable(rsel_q) && $stable(init_q))
    else $error("unit state changed without a committed item");

  // A mask write outside init takes the byte
  a_mask_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && op_i.kind == KIND_WRITE && op_i.hit && op_i.odd && init_q == 2'd0
    |=> mask_q == $past(op_i.wdata))
    else $error("mask write not taken");

  // Reads leave mask, select and init count alone
  a_read_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_i && op_i.kind == KIND_READ
    |=> $stable(mask_q) && $stable(rsel_q) && $stable(init_q))
    else $error("read changed unit configuration");

endmodule

[src/cascaded_interrupt_controller.sv]
// ----------------------------------------------------------------------------
// cascaded_interrupt_controller - two cascaded 8259-style controllers
// Primary at ports 0x20/0x21, secondary at 0xa0/0xa1; the secondary's
// unmasked requests drive primary line 2. One result item per input item.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+---------------------------------------
//   req_i   | in  | valid/ready   | req_type, addr, wdata, irq_line
//   rsp_o   | out | valid/ready   | rdata, cpu_irq, bad_command
//
// The item lands in the input register, then the unit logic updates state
// and loads the result register in one step.
// One item per cycle is sustained unless rsp_o stalls; the result register
// parts the two sides, so a new item enters while a finished result waits
// to be taken. A stall on rsp_o holds the input register; req_i.ready falls
// only when both registers are full and the result is not taken.
// Reset: masks all ones, requests and in-service clear, read select buffered.
// ----------------------------------------------------------------------------
module cascaded_interrupt_controller import cic_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  cic_req_if.sink      req_i,
  cic_rsp_if.source    rsp_o
);

  // Input register
  logic        s1_valid_q;
  cic_kind_e   s1_kind_q;
  logic [15:0] s1_addr_q;
  logic [7:0]  s1_wdata_q;
  logic [3:0]  s1_line_q;

  // Result register
  logic        out_valid_q;
  logic [7:0]  rdata_q, rdata_d;
  logic        irq_q, irq_d;
  logic        bad_q, bad_d;

  logic        s1_adv;
  logic        commit;

  cic_op_t     op_pri, op_sec;
  cic_state_t  cur_pri, cur_sec, nxt_pri, nxt_sec;
  logic [7:0]  req_eff_pri;
  logic [7:0]  rdata_pri, rdata_sec;
  logic        bad_pri, bad_sec;
  logic        casc_cur, casc_nxt;
  logic [7:0]  line_bit;

  // Advance the input register whenever the result register frees up
  assign s1_adv      = !out_valid_q || rsp_o.ready;
  assign commit      = s1_valid_q && s1_adv;
  assign req_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) s1_valid_q <= req_i.valid;
      if (s1_adv)      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_kind_q  <= cic_kind_e'(req_i.req_type);
      s1_addr_q  <= req_i.addr;
      s1_wdata_q <= req_i.wdata;
      s1_line_q  <= req_i.irq_line;
    end
    if (commit) begin
      rdata_q <= rdata_d;
      irq_q   <= irq_d;
      bad_q   <= bad_d;
    end
  end

  // Decode the item for each unit
  assign line_bit = 8'd1 << s1_line_q[2:0];

  assign op_pri = '{kind:     s1_kind_q,
                    hit:      s1_addr_q[15:1] == PRI_BASE[15:1],
                    odd:      s1_addr_q[0],
                    wdata:    s1_wdata_q,
                    line_hit: !s1_line_q[3],
                    line_bit: line_bit};

  assign op_sec = '{kind:     s1_kind_q,
                    hit:      s1_addr_q[15:1] == SEC_BASE[15:1],
                    odd:      s1_addr_q[0],
                    wdata:    s1_wdata_q,
                    line_hit: s1_line_q[3],
                    line_bit: line_bit};

  // Primary line 2 always follows the secondary's unmasked requests
  assign casc_cur    = |(cur_sec.req & ~cur_sec.mask);
  assign req_eff_pri = {cur_pri.req[7:3], casc_cur, cur_pri.req[1:0]};
  assign casc_nxt    = |(nxt_sec.req & ~nxt_sec.mask);

  cic_unit u_pri (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .commit_i  (commit),
    .op_i      (op_pri),
    .req_eff_i (req_eff_pri),
    .cur_o     (cur_pri),
    .nxt_o     (nxt_pri),
    .rdata_o   (rdata_pri),
    .bad_o     (bad_pri)
  );

  cic_unit u_sec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .commit_i  (commit),
    .op_i      (op_sec),
    .req_eff_i (cur_sec.req),
    .cur_o     (cur_sec),
    .nxt_o     (nxt_sec),
    .rdata_o   (rdata_sec),
    .bad_o     (bad_sec)
  );

  // At most one unit is addressed, so OR the per-unit answers
  assign rdata_d = rdata_pri | rdata_sec;
  assign bad_d   = bad_pri | bad_sec;
  // CPU interrupt: primary has an unmasked request after the item
  assign irq_d   = |({nxt_pri.req[7:3], casc_nxt, nxt_pri.req[1:0]} & ~nxt_pri.mask);

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.rdata       = rdata_q;
  assign rsp_o.cpu_irq     = irq_q;
  assign rsp_o.bad_command = bad_q;

  // A committed item always shows up as a result next cycle
  a_commit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> rsp_o.valid)
    else $error("committed item produced no result");

  // Only writes flag bad commands, and writes return no data
  a_bad_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.bad_command |-> rsp_o.rdata == 8'd0)
    else $error("bad command carries read data");

  // Back-pressure only when both registers are full and stalled
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> s1_valid_q && out_valid_q && !rsp_o.ready)
    else $error("input stalled without a full pipeline");

endmodule

[test/cic_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cic_tb_pkg - item types and scoreboard for the interrupt controller bench
// Holds a cycle-free model of both controller units, predicts the status of
// every accepted item and compares it with the items leaving the block.
// ----------------------------------------------------------------------------
package cic_tb_pkg;
  import cic_pkg::*;

  typedef struct packed {
    cic_kind_e   kind;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [3:0]  line;
  } pic_item_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       cpu_irq;
    logic       bad_command;
  } pic_status_t;

  class pic_scoreboard;
    logic [7:0]  mask_w[2];
    logic [7:0]  req_w[2];
    logic [7:0]  isr_w[2];
    logic [1:0]  rsel[2];
    logic [1:0]  icw_left[2];
    pic_status_t expected_status[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      for (int u = 0; u < 2; u++) begin
        mask_w[u]   = MASK_RESET;
        req_w[u]    = '0;
        isr_w[u]    = '0;
        rsel[u]     = RSEL_BUF;
        icw_left[u] = '0;
      end
      errors  = 0;
      checked = 0;
    endfunction

    function int unit_of(logic [15:0] a);
      if ({a[15:1], 1'b0} == PRI_BASE) return 0;
      if ({a[15:1], 1'b0} == SEC_BASE) return 1;
      return -1;
    endfunction

    // Refresh the cascade bit, then pick the lowest unmasked request per unit.
    function void settle();
      logic [7:0] pend;
      req_w[0][2] = |(req_w[1] & ~mask_w[1]);
      for (int u = 0; u < 2; u++) begin
        pend     = req_w[u] & ~mask_w[u];
        isr_w[u] = pend & (~pend + 8'd1);
      end
    endfunction

    function logic [7:0] bus_read(int u, logic odd);
      if (odd) return mask_w[u];
      if (rsel[u] == RSEL_RAW) return req_w[u];
      if (rsel[u] == RSEL_ISR) return isr_w[u];
      for (int i = 0; i < 8; i++)
        if (req_w[u][i]) return RD_BUF_BASE + 8'(i);
      return 8'h00;
    endfunction

    // Returns 1 on an undefined command.
    function logic bus_write(int u, logic odd, logic [7:0] d);
      if (odd) begin
        if (icw_left[u] != 2'd0) begin
          icw_left[u] = icw_left[u] - 2'd1;
        end else begin
          mask_w[u] = d;
          settle();
        end
      end else if (d == CMD_RSEL_RAW) begin
        rsel[u] = RSEL_RAW;
      end else if (d == CMD_RSEL_ISR) begin
        rsel[u] = RSEL_ISR;
      end else if (d == CMD_RSEL_BUF) begin
        rsel[u] = RSEL_BUF;
      end else if (d >= CMD_ICW1_LO && d <= CMD_ICW1_HI) begin
        icw_left[u] = ICW_WORDS + {1'b0, d[0]};
      end else if (d >= CMD_NSEOI_LO && d <= CMD_NSEOI_HI) begin
        req_w[u] &= ~isr_w[u];
        isr_w[u] = '0;
        settle();
      end else if (d >= CMD_SEOI_LO && d <= CMD_SEOI_HI) begin
        req_w[u][d[2:0]] = 1'b0;
        settle();
      end else begin
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_item(pic_item_t it);
      pic_status_t st;
      int u;
      st = '0;
      u  = unit_of(it.addr);
      case (it.kind)
        KIND_READ: begin
          if (u >= 0) st.rdata = bus_read(u, it.addr[0]);
        end
        KIND_WRITE: begin
          if (u >= 0) st.bad_command = bus_write(u, it.addr[0], it.wdata);
        end
        KIND_RAISE: begin
          req_w[it.line[3]][it.line[2:0]] = 1'b1;
          settle();
        end
        default: begin
          req_w[it.line[3]][it.line[2:0]] = 1'b0;
          settle();
        end
      endcase
      st.cpu_irq = |isr_w[0];
      expected_status.push_back(st);
    endfunction

    function int outstanding();
      return expected_status.size();
    endfunction

    task report(string msg);
      if (errors < 40) $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [7:0] rdata, logic cpu_irq, logic bad_command);
      pic_status_t st;
      if (expected_status.size() == 0) begin
        report($sformatf("result with nothing expected: rdata=%02h irq=%b bad=%b",
                         rdata, cpu_irq, bad_command));
        return;
      end
      st = expected_status.pop_front();
      if (rdata !== st.rdata)
        report($sformatf("result %0d rdata %02h, want %02h", checked, rdata, st.rdata));
      if (cpu_irq !== st.cpu_irq)
        report($sformatf("result %0d cpu_irq %b, want %b", checked, cpu_irq, st.cpu_irq));
      if (bad_command !== st.bad_command)
        report($sformatf("result %0d bad_command %b, want %b", checked, bad_command,
                         st.bad_command));
      checked++;
    endtask
  endclass

endpackage

[test/tb_cascaded_interrupt_controller.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cascaded_interrupt_controller - self-checking bench for the cascaded PIC
// Sends a directed run of bus accesses and request line events, then a long
// random run with init sequences, bursty input and a stalling receiver. Each
// result item is checked against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_cascaded_interrupt_controller;
  import cic_pkg::*;
  import cic_tb_pkg::*;

  localparam int ITEM_COUNT   = 1100;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 80;   // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES = 6;    // settle margin after the last result is taken

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  cic_req_if req_ch ();
  cic_rsp_if rsp_ch ();

  cascaded_interrupt_controller dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  pic_scoreboard board;

  always #5 clk_i = ~clk_i;

  // Abort on a hung handshake.
  int unsigned cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** cascaded_interrupt_controller: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready follows one of four stall patterns, picked at random.
  // Mode 0 never stalls, so there are clean stretches too. A hold request
  // from the stimulus drops ready until the hold-off counted here runs out.
  // --------------------------------------------------------------------------
  int unsigned rx_cycle   = 0;
  int unsigned hold_left  = 0;
  int unsigned stall_mode = 0;
  bit          hold_req   = 1'b0;

  initial rsp_ch.ready = 1'b0;

  always @(negedge clk_i) begin
    rx_cycle++;
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (rx_cycle % 200 == 0) stall_mode = $urandom_range(0, 3);
    if (hold_left != 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0:       rsp_ch.ready <= 1'b1;
        1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       rsp_ch.ready <= (rx_cycle % 5 < 3);
        default: rsp_ch.ready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  // Take results at the rising edge, before the block's own updates land.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready)
      board.check_result(rsp_ch.rdata, rsp_ch.cpu_irq, rsp_ch.bad_command);
  end

  // --------------------------------------------------------------------------
  // Sender: items go out in bursts; a random gap follows each burst.
  // --------------------------------------------------------------------------
  int burst_left = 0;

  task send_item(input pic_item_t it);
    @(negedge clk_i);
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= it.kind;
    req_ch.addr     <= it.addr;
    req_ch.wdata    <= it.wdata;
    req_ch.irq_line <= it.line;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    board.note_item(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // drop valid for the gap; the next item raises it at a later edge
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk_i);
        req_ch.valid <= 1'b0;
      end
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // Drop valid, then hold the sender until every predicted result has been taken.
  task wait_drained();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic pic_item_t make_item(cic_kind_e kind, logic [15:0] addr,
                                          logic [7:0] wdata, logic [3:0] line);
    pic_item_t it;
    it.kind  = kind;
    it.addr  = addr;
    it.wdata = wdata;
    it.line  = line;
    return it;
  endfunction

  // Mostly mapped ports and defined commands; the unused fields carry noise.
  function automatic pic_item_t random_item();
    pic_item_t   it;
    logic [15:0] port;
    int          pick;
    it.addr  = 16'($urandom);
    it.wdata = 8'($urandom);
    it.line  = 4'($urandom);
    case ($urandom_range(0, 3))
      0:       port = PRI_BASE;
      1:       port = PRI_BASE | 16'h0001;
      2:       port = SEC_BASE;
      default: port = SEC_BASE | 16'h0001;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.kind = KIND_RAISE;
    end else if (pick < 42) begin
      it.kind = KIND_DROP;
    end else if (pick < 62) begin
      it.kind = KIND_READ;
      if ($urandom_range(0, 9) != 0) it.addr = port;
    end else begin
      it.kind = KIND_WRITE;
      if ($urandom_range(0, 9) != 0) it.addr = port;
      if (!it.addr[0]) begin
        case ($urandom_range(0, 5))
          0:       it.wdata = CMD_RSEL_RAW + 8'($urandom_range(0, 2));
          1, 2:    it.wdata = CMD_NSEOI_LO + 8'($urandom_range(0, 7));
          3:       it.wdata = CMD_SEOI_LO + 8'($urandom_range(0, 7));
          default: ;  // keep the random byte: mostly undefined commands
        endcase
      end else if ($urandom_range(0, 1) != 0) begin
        // sparse masks leave most lines open
        it.wdata = 8'($urandom) & 8'($urandom);
      end
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    pic_item_t   directed[$];
    pic_item_t   it;
    logic [15:0] base;
    int          words;
    int          sent;
    bit          hold_done;
    bit          pause_done;

    req_ch.valid    = 1'b0;
    req_ch.req_type = KIND_READ;
    req_ch.addr     = '0;
    req_ch.wdata    = '0;
    req_ch.irq_line = '0;
    board = new();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset values: buffered read with no request, both masks all ones.
    directed.push_back(make_item(KIND_READ, PRI_BASE, 8'h00, 4'd0));
    directed.push_back(make_item(KIND_READ, PRI_BASE | 16'h0001, 8'h00, 4'd0));
    directed.push_back(make_item(KIND_READ, SEC_BASE | 16'h0001, 8'h00, 4'd0));
    // A masked request stays quiet until the mask opens.
    directed.push_back(make_item(KIND_RAISE, 16'h0000, 8'h00, 4'd0));
    directed.push_back(make_item(KIND_WRITE, PRI_BASE | 16'h0001, 8'h00, 4'd0));
    // Secondary line 15 reaches the CPU through the cascade bit.
    directed.push_back(make_item(KIND_RAISE, 16'h0000, 8'h00, 4'd15));
    directed.push_back(make_item(KIND_WRITE, SEC_BASE | 16'h0001, 8'h00, 4'd0));
    directed.push_back(make_item(KIND_READ, PRI_BASE, 8'h00, 4'd0));
    // Every read-select mode.
    directed.push_back(make_item(KIND_WRITE, PRI_BASE, CMD_RSEL_RAW, 4'd0));
    directed.push_back(make_item(KIND_READ, PRI_BASE, 8'h00, 4'd0));
    directed.push_back(make_item(KIND_WRITE, PRI_BASE, CMD_RSEL_ISR, 4'd0));
    directed.push_back(make_item(KIND_READ, PRI_BASE, 8'h00, 4'd0));
    // Non-specific and specific end of interrupt.
    directed.push_back(make_item(KIND_WRITE, PRI_BASE, CMD_NSEOI_LO, 4'd0));
    directed.push_back(make_item(KIND_WRITE, SEC_BASE, CMD_SEOI_HI, 4'd0));
    // Primary line 2 is owned by the cascade: raise and drop do not stick.
    directed.push_back(make_item(KIND_RAISE, 16'h0000, 8'h00, 4'd2));
    directed.push_back(make_item(KIND_DROP, 16'h0000, 8'h00, 4'd2));
    // Undefined commands.
    directed.push_back(make_item(KIND_WRITE, PRI_BASE, 8'hff, 4'd0));
    directed.push_back(make_item(KIND_WRITE, SEC_BASE, 8'h00, 4'd0));
    // Init sequence with three words, then a real mask write.
    directed.push_back(make_item(KIND_WRITE, SEC_BASE, CMD_ICW1_HI, 4'd0));
    directed.push_back(make_item(KIND_WRITE, SEC_BASE | 16'h0001, 8'h55, 4'd0));
    directed.push_back(make_item(KIND_WRITE, SEC_BASE | 16'h0001, 8'haa, 4'd0));
    directed.push_back(make_item(KIND_WRITE, SEC_BASE | 16'h0001, 8'hff, 4'd0));
    directed.push_back(make_item(KIND_WRITE, SEC_BASE | 16'h0001, 8'h00, 4'd0));
    // Unmapped ports, then back to buffered mode.
    directed.push_back(make_item(KIND_READ, 16'hffff, 8'h00, 4'd0));
    directed.push_back(make_item(KIND_WRITE, 16'h0000, CMD_RSEL_RAW, 4'd0));
    directed.push_back(make_item(KIND_WRITE, PRI_BASE, CMD_RSEL_BUF, 4'd0));
    directed.push_back(make_item(KIND_DROP, 16'h0000, 8'h00, 4'd0));

    foreach (directed[i]) send_item(directed[i]);
    wait_drained();

    sent       = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    while (sent < ITEM_COUNT) begin
      // Stall the receiver while items keep coming, so input backs up.
      if (!hold_done && sent >= 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      // Let the block run dry once mid-run.
      if (!pause_done && sent >= 700) begin
        wait_drained();
        pause_done = 1'b1;
      end
      if ($urandom_range(0, 19) == 0) begin
        // Init sequence: ICW1 followed by its two or three words.
        base = ($urandom_range(0, 1) != 0) ? SEC_BASE : PRI_BASE;
        it   = make_item(KIND_WRITE, base, CMD_ICW1_LO + 8'($urandom_range(0, 15)),
                         4'($urandom));
        words = 2 + it.wdata[0];
        send_item(it);
        for (int w = 0; w < words; w++)
          send_item(make_item(KIND_WRITE, base | 16'h0001, 8'($urandom), 4'($urandom)));
        sent += words + 1;
      end else begin
        send_item(random_item());
        sent++;
      end
    end

    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.errors == 0) begin
      $display("** cascaded_interrupt_controller: PASSED **");
    end else begin
      $display("** cascaded_interrupt_controller: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
src/cic_pkg.sv
src/cic_req_if.sv
src/cic_rsp_if.sv
src/cic_unit.sv
src/cascaded_interrupt_controller.sv
test/cic_tb_pkg.sv
test/tb_cascaded_interrupt_controller.sv
